// ===== hw/rtl/sgpd_pkg.sv =====
// shared constants, types and ring helpers for the squared-gap partition core
`timescale 1ns / 1ps
package sgpd_pkg;

   localparam int MAX_ITEMS = 4096;
   localparam int PTR_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int VALUE_W   = 20;
   localparam int SEG_W     = 31;
   localparam int OUT_W     = 41;
   localparam int ICPT_W    = 42;

   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

   typedef struct packed {
      logic [VALUE_W-1:0] slope;
      logic [ICPT_W-1:0]  icpt;
   } line_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_B_RL,
      ST_B_RL2,
      ST_B_RSEC,
      ST_B_MUL,
      ST_B_CMP,
      ST_INS,
      ST_F_RH,
      ST_F_LH,
      ST_F_RN,
      ST_F_MUL,
      ST_F_CMP,
      ST_EVAL1,
      ST_EVAL2,
      ST_OUT
   } state_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (32'(p) + 32'd1 >= 32'(MAX_ITEMS)) r = '0;
      else r = p + PTR_W'(1);
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == '0) r = PTR_W'(MAX_ITEMS - 1);
      else r = p - PTR_W'(1);
      return r;
   endfunction

endpackage

// ===== hw/rtl/squared_gap_partition_dp_core.sv =====
// squared-gap partition cost core: convex hull trick over a line deque in memory
// One word in, one word out. Each accepted word runs through a sequencer that
// reads the line deque from a single-port synchronous memory (one read a cycle,
// registered data). An item passes prep, the back pops (only while the deque
// holds two or more lines), insert, the front pops, evaluation and output. Each
// popped line adds a read, a multiply and a compare state, and every line is
// popped at most once; the one memory read port and the registered wide
// multiplies of the cross-multiplied back compare split each pop into these
// states. A new word is taken while the previous result still waits in the
// output register. segment_cost is written through csr_wr_en / csr_wr_data;
// the user must write it only while the core is idle, as the core does not enforce
// this. There is no clearing pass: deque entries are only read after being written.
`timescale 1ns / 1ps
module squared_gap_partition_dp_core
   import sgpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_start_req,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [OUT_W-1:0]   rsp_prefix_cost,
   input  logic               csr_wr_en,
   input  logic [SEG_W-1:0]   csr_wr_data
);

   // control state
   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [OUT_W-1:0]   prev_ff, prev_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_cost_ff, rsp_cost_in;
   logic [SEG_W-1:0]   seg_ff;

   // datapath registers
   logic [VALUE_W-1:0] x_ff;
   logic [ICPT_W-1:0]  nb_ff;
   line_type           last_ff;     // back line (last)
   line_type           sec_ff;      // line before last
   line_type           hd_ff;       // head line
   logic signed [63:0] lhs_ff, rhs_ff;
   logic signed [ICPT_W:0] db_ff, slope2x_ff;
   logic [OUT_W-1:0]   dsq_ff;
   logic [2*VALUE_W-1:0] s2_ff;

   // deque memory
   line_type           mem [MAX_ITEMS];
   line_type           rdata_ff;
   logic [PTR_W-1:0]   rd_addr;
   logic               wr_en;

   // combinational arithmetic
   logic [2*VALUE_W-1:0]   xsq;
   logic [ICPT_W-1:0]      nb_in;
   logic signed [ICPT_W:0] b_dnb, b_dbb;
   logic signed [VALUE_W:0] b_dss, b_dxs;
   logic signed [63:0]     lhs_in, rhs_in;
   logic signed [ICPT_W:0] f_db;
   logic signed [VALUE_W:0] f_ds, f_x;
   logic signed [2*VALUE_W+1:0] f_prod;
   logic signed [VALUE_W:0] e_d;
   logic signed [2*VALUE_W+1:0] e_dsq;
   logic [OUT_W+2:0]       cost_sum;
   logic [OUT_W-1:0]       cost_sat;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prefix_cost = rsp_cost_ff;

   // new line intercept for the previous prefix, full-width square
   assign xsq   = x_ff * x_ff;
   assign nb_in = ICPT_W'(prev_ff) + ICPT_W'(xsq);

   // back pop: (nb - bj) * (sj - si) >= (bj - bi) * (x - sj), sec line in rdata
   assign b_dnb  = $signed({1'b0, nb_ff}) - $signed({1'b0, rdata_ff.icpt});
   assign b_dss  = $signed({1'b0, rdata_ff.slope}) - $signed({1'b0, last_ff.slope});
   assign b_dbb  = $signed({1'b0, rdata_ff.icpt}) - $signed({1'b0, last_ff.icpt});
   assign b_dxs  = $signed({1'b0, x_ff}) - $signed({1'b0, rdata_ff.slope});
   assign lhs_in = b_dnb * b_dss;
   assign rhs_in = b_dbb * b_dxs;

   // front pop: (b1 - b0) <= 2 * x * (s1 - s0), second line in rdata
   assign f_db   = $signed({1'b0, rdata_ff.icpt}) - $signed({1'b0, hd_ff.icpt});
   assign f_ds   = $signed({1'b0, rdata_ff.slope}) - $signed({1'b0, hd_ff.slope});
   assign f_x    = $signed({1'b0, x_ff});
   assign f_prod = f_x * f_ds;

   // evaluation at the head line
   assign e_d      = $signed({1'b0, x_ff}) - $signed({1'b0, hd_ff.slope});
   assign e_dsq    = e_d * e_d;
   assign cost_sum = (OUT_W+3)'(hd_ff.icpt) - (OUT_W+3)'(s2_ff) + (OUT_W+3)'(seg_ff)
                   + (OUT_W+3)'(dsq_ff);
   assign cost_sat = (cost_sum > (OUT_W+3)'(OUT_MAX)) ? OUT_MAX : cost_sum[OUT_W-1:0];

   // sequencer: next state, pointers and memory port
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cost_in  = rsp_cost_ff;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_start_req) begin
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
                  prev_in  = '0;
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = (count_ff > CNT_W'(1)) ? ST_B_RL : ST_INS;
         end
         ST_B_RL: begin
            rd_addr  = ring_prev(tail_ff);
            state_in = ST_B_RL2;
         end
         ST_B_RL2: begin
            rd_addr  = ring_prev(ring_prev(tail_ff));
            state_in = ST_B_MUL;
         end
         ST_B_RSEC: begin
            rd_addr  = ring_prev(ring_prev(tail_ff));
            state_in = ST_B_MUL;
         end
         ST_B_MUL: begin
            state_in = ST_B_CMP;
         end
         ST_B_CMP: begin
            if (lhs_ff >= rhs_ff) begin
               tail_in  = ring_prev(tail_ff);
               count_in = count_ff - CNT_W'(1);
               state_in = (count_ff > CNT_W'(2)) ? ST_B_RSEC : ST_INS;
            end else begin
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            // full deque drops its oldest line
            if (32'(count_ff) >= 32'(MAX_ITEMS)) begin
               head_in = ring_next(head_ff);
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
            wr_en    = 1'b1;
            tail_in  = ring_next(tail_ff);
            state_in = ST_F_RH;
         end
         ST_F_RH: begin
            rd_addr  = head_ff;
            state_in = ST_F_LH;
         end
         ST_F_LH: begin
            rd_addr  = ring_next(head_ff);
            state_in = (count_ff > CNT_W'(1)) ? ST_F_MUL : ST_EVAL1;
         end
         ST_F_RN: begin
            rd_addr  = ring_next(head_ff);
            state_in = ST_F_MUL;
         end
         ST_F_MUL: begin
            state_in = ST_F_CMP;
         end
         ST_F_CMP: begin
            if (db_ff <= slope2x_ff) begin
               head_in  = ring_next(head_ff);
               count_in = count_ff - CNT_W'(1);
               state_in = (count_ff > CNT_W'(2)) ? ST_F_RN : ST_EVAL1;
            end else begin
               state_in = ST_EVAL1;
            end
         end
         ST_EVAL1: begin
            state_in = ST_EVAL2;
         end
         ST_EVAL2: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = cost_sat;
               prev_in      = cost_sat;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         seg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            seg_ff <= csr_wr_data;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      rsp_cost_ff <= rsp_cost_in;
      if (state_ff == ST_IDLE && req_valid) begin
         x_ff <= req_value;
      end
      if (state_ff == ST_PREP) begin
         nb_ff <= nb_in;
      end
      if (state_ff == ST_B_RL2) begin
         last_ff <= rdata_ff;
      end
      if (state_ff == ST_B_MUL) begin
         sec_ff <= rdata_ff;
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
      end
      // after a back pop the old second line becomes the last one
      if (state_ff == ST_B_CMP) begin
         last_ff <= sec_ff;
      end
      if (state_ff == ST_F_LH) begin
         hd_ff <= rdata_ff;
      end
      if (state_ff == ST_F_MUL) begin
         sec_ff     <= rdata_ff;
         db_ff      <= f_db;
         slope2x_ff <= {f_prod[ICPT_W-1:0], 1'b0};
      end
      if (state_ff == ST_F_CMP && db_ff <= slope2x_ff) begin
         hd_ff <= sec_ff;
      end
      if (state_ff == ST_EVAL1) begin
         dsq_ff <= e_dsq[OUT_W-1:0];
         s2_ff  <= hd_ff.slope * hd_ff.slope;
      end
   end

   // deque storage, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= '{slope: x_ff, icpt: nb_ff};
      end
      rdata_ff <= mem[rd_addr];
   end

   // fill level never exceeds the deque size
   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_ITEMS))
      else $error("deque count overflow");

   // ring pointers agree with the fill level
   assert property (@(posedge clock) disable iff (reset)
      (tail_ff - head_ff) == count_ff[PTR_W-1:0] ||
      32'(count_ff) == 32'(MAX_ITEMS))
      else $error("deque pointers disagree with count");

   // evaluation always has a head line
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL1 |-> count_ff != '0)
      else $error("evaluation on empty deque");

   // one word at a time through the sequencer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");

endmodule
